// File: src/vehicle_kinematic_step_defines.svh
// Assertion macros shared by the vehicle kinematic step design.
`ifndef VEHICLE_KINEMATIC_STEP_DEFINES_SVH
`define VEHICLE_KINEMATIC_STEP_DEFINES_SVH

// A condition that must imply a property in the same cycle.
`define VKS_CHECK(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("vks check failed");

// A condition that must never hold.
`define VKS_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("vks forbidden condition");

`endif

// File: src/vks_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package vks_pkg;

  localparam int CORDIC_ITER_DEF = 16;
  localparam int RED_STEPS = 14;

  localparam logic [20:0] STEP_RESET = 21'd6554;

  // Angle constants in Q2.30.
  localparam logic [46:0] TWO_PI_W = 47'd6746518852;
  localparam logic signed [33:0] TWO_PI_Q30 = 34'sd6746518852;
  localparam logic signed [33:0] PI_Q30 = 34'sd3373259426;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

  typedef struct packed {
    logic signed [31:0] fwd_accel_now;
    logic signed [31:0] fwd_accel_next;
    logic signed [31:0] fwd_speed_now;
    logic signed [31:0] steer_now;
    logic signed [31:0] steer_next;
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] heading;
  } in_t;

  typedef struct packed {
    logic signed [31:0] new_fwd_speed;
    logic signed [31:0] new_heading;
    logic signed [31:0] new_accel_x;
    logic signed [31:0] new_accel_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
  } out_t;

  // Front stages carry the whole request plus the values built so far.
  typedef struct packed {
    in_t                d;
    logic signed [31:0] mean_a;
    logic signed [31:0] mean_s;
    logic signed [31:0] v1;
    logic signed [31:0] mv;
    logic signed [31:0] w;
    logic signed [31:0] h1;
  } early_t;

  // Values that ride alongside the angle reduction and rotation cells.
  typedef struct packed {
    logic signed [31:0] a1;
    logic signed [31:0] ax0;
    logic signed [31:0] ay0;
    logic signed [31:0] vx0;
    logic signed [31:0] vy0;
    logic signed [31:0] px0;
    logic signed [31:0] py0;
    logic signed [31:0] v1;
    logic signed [31:0] h1;
  } side_t;

  typedef struct packed {
    side_t              sd;
    logic signed [31:0] ax1;
    logic signed [31:0] ay1;
    logic signed [31:0] vx1;
    logic signed [31:0] vy1;
  } tail_t;

  // Clamp a wide value to signed 32 bits.
  function automatic logic signed [31:0] sat32(logic signed [71:0] v);
    logic signed [31:0] r;
    if (v > 72'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -72'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Floor of the mean of two values.
  function automatic logic signed [31:0] mean2(logic signed [31:0] a,
                                               logic signed [31:0] b);
    logic signed [32:0] s;
    s = 33'(a) + 33'(b);
    return s[32:1];
  endfunction

  // Value times the step length, rounded half up.
  function automatic logic signed [37:0] times_dt(logic signed [31:0] a,
                                                  logic [20:0] dt);
    logic signed [53:0] p;
    p = 54'(a) * 54'($signed({1'b0, dt}));
    p = p + 54'sd32768;
    return p[53:16];
  endfunction

  // Arctangent table in Q2.30.
  function automatic logic signed [33:0] atan_q30(int i);
    logic signed [33:0] r;
    case (i)
      0:  r = 34'sd843314856;
      1:  r = 34'sd497837829;
      2:  r = 34'sd263043836;
      3:  r = 34'sd133525158;
      4:  r = 34'sd67021686;
      5:  r = 34'sd33543515;
      6:  r = 34'sd16775850;
      7:  r = 34'sd8388437;
      8:  r = 34'sd4194282;
      9:  r = 34'sd2097149;
      10: r = 34'sd1048575;
      11: r = 34'sd524287;
      12: r = 34'sd262143;
      13: r = 34'sd131071;
      14: r = 34'sd65535;
      15: r = 34'sd32767;
      16: r = 34'sd16383;
      17: r = 34'sd8191;
      18: r = 34'sd4095;
      19: r = 34'sd2047;
      20: r = 34'sd1023;
      21: r = 34'sd511;
      22: r = 34'sd255;
      23: r = 34'sd127;
      24: r = 34'sd63;
      25: r = 34'sd31;
      26: r = 34'sd15;
      27: r = 34'sd8;
      28: r = 34'sd4;
      29: r = 34'sd2;
      30: r = 34'sd1;
      default: r = 34'sd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: src/vks_mod_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module vks_mod_cell #(
  parameter int K = 0
) (
  input  wire logic        clk,
  input  wire logic [46:0] u_i,
  output logic [46:0]      u_o
);
  import vks_pkg::*;

  localparam logic [46:0] THRESH = TWO_PI_W << K;

  logic [46:0] u_r;
  logic [46:0] u_nxt;

  // One restoring step of the reduction by two pi.
  always_comb begin
    if (u_i >= THRESH) begin
      u_nxt = u_i - THRESH;
    end else begin
      u_nxt = u_i;
    end
  end

  always_ff @(posedge clk) begin
    u_r <= u_nxt;
  end

  assign u_o = u_r;
endmodule
`default_nettype wire

// File: src/vks_cordic_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module vks_cordic_cell #(
  parameter int IDX = 0
) (
  input  wire logic               clk,
  input  wire logic signed [33:0] x_i,
  input  wire logic signed [33:0] y_i,
  input  wire logic signed [33:0] z_i,
  output logic signed [33:0]      x_o,
  output logic signed [33:0]      y_o,
  output logic signed [33:0]      z_o
);
  import vks_pkg::*;

  localparam logic signed [33:0] ATAN = atan_q30(IDX);

  logic signed [33:0] x_r, y_r, z_r;
  logic signed [33:0] x_nxt, y_nxt, z_nxt;
  logic signed [33:0] dx, dy;

  // One rotation step, direction from the sign of the residual angle.
  always_comb begin
    dx = y_i >>> IDX;
    dy = x_i >>> IDX;
    if (!z_i[33]) begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      z_nxt = z_i - ATAN;
    end else begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      z_nxt = z_i + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;
endmodule
`default_nettype wire

// File: src/vehicle_kinematic_step.sv
`timescale 1ns / 1ps
`default_nettype none
// Advances one vehicle state by one time step per request. A request is taken at
// every clock edge where start is high; busy is always low, so one request per
// cycle is sustained. Each result appears on out_data for exactly one cycle with
// out_valid high. The pipeline has CORDIC_ITERATIONS + 26 registers, in order:
// a capture stage and five front stages, one offset stage, fourteen angle
// reduction cells, one fold stage, one rotation cell per CORDIC iteration and four
// back stages. The receiver cannot stall the block and must take every result as
// it appears. The user must write the step length through cfg_we and cfg_wdata
// only while no request is in flight; the block itself does not enforce this.
module vehicle_kinematic_step #(
  parameter int CORDIC_ITERATIONS = vks_pkg::CORDIC_ITER_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire vks_pkg::in_t  in_data,
  output logic               out_valid,
  output vks_pkg::out_t      out_data,
  input  wire logic          cfg_we,
  input  wire logic [20:0]   cfg_wdata
);
  import vks_pkg::*;

  localparam int N = CORDIC_ITERATIONS;
  localparam int SD_LEN = RED_STEPS + N + 3;
  localparam int FOLD_AT = RED_STEPS + 1;
  localparam int FLIP_AT = RED_STEPS + N + 2;
  localparam int LAT = N + 25;
  localparam logic [46:0] OFFSET = TWO_PI_W << (RED_STEPS - 1);

  logic [20:0] dt_r;

  // Step length register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r <= STEP_RESET;
    end else if (cfg_we) begin
      dt_r <= cfg_wdata;
    end
  end

  assign busy = 1'b0;

  // Request capture.
  in_t  in_r;
  logic ev_r [0:5];
  always_ff @(posedge clk) begin
    if (start) begin
      in_r <= in_data;
    end
  end

  // Front stages: speed, turn rate and heading.
  early_t e_r   [1:5];
  early_t e_nxt [1:5];
  always_comb begin
    e_nxt[1] = '0;
    e_nxt[1].d = in_r;
    e_nxt[1].mean_a = mean2(in_r.fwd_accel_now, in_r.fwd_accel_next);
    e_nxt[1].mean_s = mean2(in_r.steer_now, in_r.steer_next);

    e_nxt[2] = e_r[1];
    e_nxt[2].v1 = sat32(72'(e_r[1].d.fwd_speed_now) + 72'(times_dt(e_r[1].mean_a, dt_r)));

    e_nxt[3] = e_r[2];
    e_nxt[3].mv = mean2(e_r[2].d.fwd_speed_now, e_r[2].v1);

    e_nxt[4] = e_r[3];
    e_nxt[4].w = sat32(72'($signed(
      (64'(e_r[3].mean_s) * 64'(e_r[3].mv) + 64'sd32768) >>> 16)));

    e_nxt[5] = e_r[4];
    e_nxt[5].h1 = sat32(72'(e_r[4].d.heading) + 72'(times_dt(e_r[4].w, dt_r)));
  end

  always_ff @(posedge clk) begin
    for (int k = 1; k <= 5; k++) begin
      e_r[k] <= e_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= 5; k++) begin
        ev_r[k] <= 1'b0;
      end
    end else begin
      ev_r[0] <= start;
      for (int k = 1; k <= 5; k++) begin
        ev_r[k] <= ev_r[k-1];
      end
    end
  end

  // Side line that runs in step with the cells.
  side_t sd_r  [0:SD_LEN-1];
  logic  sdv_r [0:SD_LEN-1];
  side_t sd_in;
  logic [46:0] u_r;
  logic signed [46:0] h_wide;

  always_comb begin
    sd_in.a1  = e_r[5].d.fwd_accel_next;
    sd_in.ax0 = e_r[5].d.accel_x;
    sd_in.ay0 = e_r[5].d.accel_y;
    sd_in.vx0 = e_r[5].d.vel_x;
    sd_in.vy0 = e_r[5].d.vel_y;
    sd_in.px0 = e_r[5].d.pos_x;
    sd_in.py0 = e_r[5].d.pos_y;
    sd_in.v1  = e_r[5].v1;
    sd_in.h1  = e_r[5].h1;
    h_wide = {e_r[5].h1[31], e_r[5].h1, 14'd0};
  end

  // Heading in Q2.30 moved up by a multiple of two pi so it is never negative.
  always_ff @(posedge clk) begin
    u_r <= 47'(h_wide) + OFFSET;
    sd_r[0] <= sd_in;
    for (int k = 1; k < SD_LEN; k++) begin
      sd_r[k] <= sd_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SD_LEN; k++) begin
        sdv_r[k] <= 1'b0;
      end
    end else begin
      sdv_r[0] <= ev_r[5];
      for (int k = 1; k < SD_LEN; k++) begin
        sdv_r[k] <= sdv_r[k-1];
      end
    end
  end

  // Reduction cells, largest multiple of two pi first.
  logic [46:0] red_u [0:RED_STEPS];
  assign red_u[0] = u_r;
  for (genvar j = 0; j < RED_STEPS; j++) begin : g_red
    vks_mod_cell #(.K(RED_STEPS - 1 - j)) u_cell (
      .clk (clk),
      .u_i (red_u[j]),
      .u_o (red_u[j+1])
    );
  end

  // Fold the angle into the half plane the rotation cells cover.
  logic signed [33:0] zr, zc, zf_r;
  logic               flip_nxt, flip_r;
  always_comb begin
    zr = $signed(red_u[RED_STEPS][33:0]);
    if (zr >= PI_Q30) begin
      zr = zr - TWO_PI_Q30;
    end
    flip_nxt = 1'b0;
    zc = zr;
    if (zr > HALF_PI_Q30) begin
      zc = zr - PI_Q30;
      flip_nxt = 1'b1;
    end else if (zr < -HALF_PI_Q30) begin
      zc = zr + PI_Q30;
      flip_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    zf_r <= zc;
    flip_r <= flip_nxt;
  end

  // Fold flags travel with the rotation cells.
  logic fl_r [0:N-1];
  always_ff @(posedge clk) begin
    fl_r[0] <= flip_r;
    for (int k = 1; k < N; k++) begin
      fl_r[k] <= fl_r[k-1];
    end
  end

  // Rotation cells.
  logic signed [33:0] cx [0:N];
  logic signed [33:0] cy [0:N];
  logic signed [33:0] cz [0:N];
  assign cx[0] = GAIN_Q30;
  assign cy[0] = '0;
  assign cz[0] = zf_r;
  for (genvar i = 0; i < N; i++) begin : g_cordic
    vks_cordic_cell #(.IDX(i)) u_cell (
      .clk (clk),
      .x_i (cx[i]),
      .y_i (cy[i]),
      .z_i (cz[i]),
      .x_o (cx[i+1]),
      .y_o (cy[i+1]),
      .z_o (cz[i+1])
    );
  end

  // Undo the fold on cosine and sine.
  logic signed [33:0] cos_r, sin_r;
  always_ff @(posedge clk) begin
    if (fl_r[N-1]) begin
      cos_r <= -cx[N];
      sin_r <= -cy[N];
    end else begin
      cos_r <= cx[N];
      sin_r <= cy[N];
    end
  end

  // Back stages: rotated acceleration, velocity, position.
  tail_t mul_r, vel_r, mul_nxt, vel_nxt;
  out_t  out_r, out_nxt;
  logic  mulv_r, velv_r, outv_r;
  side_t sdf;
  logic signed [65:0] pcx, pcy;

  always_comb begin
    sdf = sd_r[FLIP_AT];
    pcx = 66'(sdf.a1) * 66'(cos_r) + 66'sd536870912;
    pcy = 66'(sdf.a1) * 66'(sin_r) + 66'sd536870912;
    mul_nxt = '0;
    mul_nxt.sd = sdf;
    mul_nxt.ax1 = sat32(72'($signed(pcx[65:30])));
    mul_nxt.ay1 = sat32(72'($signed(pcy[65:30])));

    vel_nxt = mul_r;
    vel_nxt.vx1 = sat32(72'(mul_r.sd.vx0)
                  + 72'(times_dt(mean2(mul_r.sd.ax0, mul_r.ax1), dt_r)));
    vel_nxt.vy1 = sat32(72'(mul_r.sd.vy0)
                  + 72'(times_dt(mean2(mul_r.sd.ay0, mul_r.ay1), dt_r)));

    out_nxt.new_fwd_speed = vel_r.sd.v1;
    out_nxt.new_heading   = vel_r.sd.h1;
    out_nxt.new_accel_x   = vel_r.ax1;
    out_nxt.new_accel_y   = vel_r.ay1;
    out_nxt.new_vel_x     = vel_r.vx1;
    out_nxt.new_vel_y     = vel_r.vy1;
    out_nxt.new_pos_x = sat32(72'(vel_r.sd.px0)
                        + 72'(times_dt(mean2(vel_r.sd.vx0, vel_r.vx1), dt_r)));
    out_nxt.new_pos_y = sat32(72'(vel_r.sd.py0)
                        + 72'(times_dt(mean2(vel_r.sd.vy0, vel_r.vy1), dt_r)));
  end

  always_ff @(posedge clk) begin
    mul_r <= mul_nxt;
    vel_r <= vel_nxt;
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mulv_r <= 1'b0;
      velv_r <= 1'b0;
      outv_r <= 1'b0;
    end else begin
      mulv_r <= sdv_r[FLIP_AT];
      velv_r <= mulv_r;
      outv_r <= velv_r;
    end
  end

  assign out_valid = outv_r;
  assign out_data  = out_r;

  // Checks on the reduction, the fold and the pipeline timing.
`include "vehicle_kinematic_step_defines.svh"
  `VKS_NEVER(a_red_range, sdv_r[RED_STEPS] && (red_u[RED_STEPS] >= TWO_PI_W))
  `VKS_CHECK(a_fold_range, sdv_r[FOLD_AT], (zf_r <= HALF_PI_Q30) && (zf_r >= -HALF_PI_Q30))
  `VKS_CHECK(a_latency, out_valid, $past(ev_r[0], LAT))
endmodule
`default_nettype wire
